// ----- rtl/rlc_pkg.sv -----
// ----------------------------------------------------------------------------
// rlc_pkg: shared types and constants of the rgb light crossfade block
// Command codes, payload structs, fixed-point widths and reset values.
// ----------------------------------------------------------------------------
package rlc_pkg;

    // fixed-point progress format
    localparam int FRACTION_BITS = 16;
    localparam int STEP_W        = 17;
    localparam int PROG_W        = ((FRACTION_BITS > STEP_W) ? FRACTION_BITS : STEP_W) + 1;
    localparam int MUL_B_W       = FRACTION_BITS + 1;
    localparam int PROD_W        = FRACTION_BITS + 10;

    localparam logic [PROG_W-1:0] ONE_Q =
        {{(PROG_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_STEP = 2'd1;
    localparam logic [STEP_W-1:0] NORMAL_STEP_RST = 17'd197;
    localparam logic [STEP_W-1:0] SWITCH_STEP_RST = 17'd66;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_ON        = 3'd1,
        CMD_OFF       = 3'd2,
        CMD_SET_LEVEL = 3'd3,
        CMD_SET_COLOR = 3'd4
    } t_cmd;

    // slots of a setting: level, red, green, blue
    typedef logic [3:0][7:0] t_quad;
    localparam logic [1:0] SLOT_LEVEL = 2'd0;
    localparam logic [1:0] SLOT_RED   = 2'd1;
    localparam logic [1:0] SLOT_GREEN = 2'd2;
    localparam logic [1:0] SLOT_BLUE  = 2'd3;
    localparam t_quad GOAL_RST  = {8'd48, 8'd0, 8'd0, 8'd255};
    localparam t_quad START_RST = {8'd0, 8'd0, 8'd0, 8'd0};

    // request payloads
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] new_level;
        logic [7:0] new_red;
        logic [7:0] new_green;
        logic [7:0] new_blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       still_fading;
    } t_out;

    // shared multiply unit interface
    typedef struct packed {
        logic                     is_blend;
        logic signed [8:0]        mul_a;
        logic        [MUL_B_W-1:0] mul_b;
        logic        [7:0]        base;
    } t_mac_req;

endpackage

// ----- rtl/rgb_light_crossfade.sv -----
// ----------------------------------------------------------------------------
// rgb_light_crossfade: rgb light controller with linear crossfades
// Switch, level and color requests start fades; each tick advances the fade
// and returns the dimmed channel drive values for the next frame.
//
//   channel | direction | handshake               | payload
//   in      | to block  | i_in_valid / o_in_stall  | i_in_data  (rlc_pkg::t_in)
//   out     | from block| o_out_valid / i_out_stall| o_out_data (rlc_pkg::t_out)
//   cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// non-tick requests complete in the accept cycle
// a tick runs four blends and three dims while fading, each through the one
// shared multiplier in a multiply and a post state, and only the three dims otherwise
// a tick also waits for a result still held in the output register
// synchronous active-low reset restores the power-on setting and step values
// ----------------------------------------------------------------------------
module rgb_light_crossfade (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rlc_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rlc_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rlc_pkg::STEP_W-1:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_POST = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    localparam logic [2:0] IDX_DIM_FIRST = 3'd4;
    localparam logic [2:0] IDX_LAST      = 3'd6;

    t_state                      r_state, n_state;
    logic [2:0]                  r_idx, n_idx;
    logic                        r_lit, n_lit;
    logic                        r_fading, n_fading;
    rlc_pkg::t_quad              r_goal, n_goal;
    rlc_pkg::t_quad              r_start, n_start;
    rlc_pkg::t_quad              r_work, n_work;
    logic [rlc_pkg::PROG_W-1:0]  r_prog, n_prog;
    logic [rlc_pkg::STEP_W-1:0]  r_step, n_step;
    logic [rlc_pkg::STEP_W-1:0]  r_normal_step, r_switch_step;
    rlc_pkg::t_out               r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        in_acc;
    logic                        out_free;
    logic [rlc_pkg::PROG_W-1:0]  prog_sum;
    logic [1:0]                  dim_slot;
    rlc_pkg::t_mac_req           mac_req;
    logic [7:0]                  mac_value;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign prog_sum    = r_prog + rlc_pkg::PROG_W'(r_step);
    assign dim_slot    = r_idx[1:0] + 2'd1;

    // shared unit operands by step index
    always_comb begin
        if (r_idx < IDX_DIM_FIRST) begin
            mac_req.is_blend = 1'b1;
            mac_req.mul_a    = $signed({1'b0, r_goal[r_idx[1:0]]})
                             - $signed({1'b0, r_start[r_idx[1:0]]});
            mac_req.mul_b    = {1'b0, r_prog[rlc_pkg::FRACTION_BITS-1:0]};
            mac_req.base     = r_start[r_idx[1:0]];
        end else begin
            mac_req.is_blend = 1'b0;
            mac_req.mul_a    = $signed({1'b0, r_work[dim_slot]});
            mac_req.mul_b    = rlc_pkg::MUL_B_W'(r_work[rlc_pkg::SLOT_LEVEL]);
            mac_req.base     = 8'd0;
        end
    end

    rlc_mac u_mac (
        .i_clk   (i_clk),
        .i_req   (mac_req),
        .o_value (mac_value)
    );

    // sequencer and state updates
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_lit       = r_lit;
        n_fading    = r_fading;
        n_goal      = r_goal;
        n_start     = r_start;
        n_work      = r_work;
        n_prog      = r_prog;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.cmd)
                        rlc_pkg::CMD_TICK: begin
                            n_work  = r_goal;
                            n_idx   = IDX_DIM_FIRST;
                            n_state = ST_MUL;
                            if (r_fading) begin
                                n_prog = prog_sum;
                                if (prog_sum >= rlc_pkg::ONE_Q) begin
                                    n_fading = 1'b0;
                                end else begin
                                    n_idx = 3'd0;
                                end
                            end
                        end
                        rlc_pkg::CMD_ON: begin
                            if (!r_lit) begin
                                n_lit    = 1'b1;
                                n_start  = r_goal;
                                n_goal   = r_start;
                                n_fading = 1'b1;
                                n_prog   = '0;
                                n_step   = r_switch_step;
                            end
                        end
                        rlc_pkg::CMD_OFF: begin
                            if (r_lit) begin
                                n_lit    = 1'b0;
                                n_start  = r_goal;
                                n_goal   = '0;
                                n_fading = 1'b1;
                                n_prog   = '0;
                                n_step   = r_switch_step;
                            end
                        end
                        rlc_pkg::CMD_SET_LEVEL: begin
                            if (r_lit) begin
                                n_start  = r_goal;
                                n_goal[rlc_pkg::SLOT_LEVEL] = i_in_data.new_level;
                                n_fading = 1'b1;
                                n_prog   = '0;
                                n_step   = r_normal_step;
                            end else begin
                                n_start[rlc_pkg::SLOT_LEVEL] = i_in_data.new_level;
                            end
                        end
                        rlc_pkg::CMD_SET_COLOR: begin
                            if (r_lit) begin
                                n_start  = r_goal;
                                n_goal[rlc_pkg::SLOT_RED]   = i_in_data.new_red;
                                n_goal[rlc_pkg::SLOT_GREEN] = i_in_data.new_green;
                                n_goal[rlc_pkg::SLOT_BLUE]  = i_in_data.new_blue;
                                n_fading = 1'b1;
                                n_prog   = '0;
                                n_step   = r_normal_step;
                            end else begin
                                n_start[rlc_pkg::SLOT_RED]   = i_in_data.new_red;
                                n_start[rlc_pkg::SLOT_GREEN] = i_in_data.new_green;
                                n_start[rlc_pkg::SLOT_BLUE]  = i_in_data.new_blue;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                if (r_idx < IDX_DIM_FIRST) begin
                    n_work[r_idx[1:0]] = mac_value;
                end else begin
                    n_work[dim_slot] = mac_value;
                end
                if (r_idx == IDX_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx   = r_idx + 3'd1;
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out.out_red      = r_work[rlc_pkg::SLOT_RED];
                    n_out.out_green    = r_work[rlc_pkg::SLOT_GREEN];
                    n_out.out_blue     = r_work[rlc_pkg::SLOT_BLUE];
                    n_out.still_fading = r_fading;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and setting registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_lit       <= 1'b1;
            r_fading    <= 1'b0;
            r_goal      <= rlc_pkg::GOAL_RST;
            r_start     <= rlc_pkg::START_RST;
            r_prog      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_lit       <= n_lit;
            r_fading    <= n_fading;
            r_goal      <= n_goal;
            r_start     <= n_start;
            r_prog      <= n_prog;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // working values and output payload
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_out  <= n_out;
    end

    // step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_step <= rlc_pkg::NORMAL_STEP_RST;
            r_switch_step <= rlc_pkg::SWITCH_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == rlc_pkg::REG_NORMAL_STEP) begin
                r_normal_step <= i_cfg_data;
            end
            if (i_cfg_index == rlc_pkg::REG_SWITCH_STEP) begin
                r_switch_step <= i_cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    // a tick always starts the sequencer
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.cmd == rlc_pkg::CMD_TICK) |=> (r_state == ST_MUL))
        else $error("tick did not start the sequencer");

    // other requests finish in the accept cycle
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.cmd != rlc_pkg::CMD_TICK) |=> (r_state == ST_IDLE))
        else $error("non-tick request held the block");

    // the step index never runs past the last dim step
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_idx <= IDX_LAST))
        else $error("step index out of range");

    // a product is only consumed in the cycle after it was issued
    a_post_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST) |-> ($past(r_state) == ST_MUL))
        else $error("post step without multiply");

    // a blend step only runs during an unfinished fade
    a_blend_fading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) && (r_idx < IDX_DIM_FIRST)
        |-> r_fading && (r_prog < rlc_pkg::ONE_Q))
        else $error("blend outside a running fade");
`endif

endmodule

// ----- rtl/rlc_mac.sv -----
// ----------------------------------------------------------------------------
// rlc_mac: shared multiply unit of the crossfade block
// One registered signed multiply; the next cycle turns the product into either
// a floored linear blend or a color * level / 255 dimming value.
// ----------------------------------------------------------------------------
module rlc_mac (
    input  logic              i_clk,
    input  rlc_pkg::t_mac_req i_req,
    output logic [7:0]        o_value
);

    logic signed [rlc_pkg::PROD_W-1:0] r_prod;
    logic                              r_is_blend;
    logic        [7:0]                 r_base;
    logic signed [rlc_pkg::PROD_W-1:0] blend_acc;
    logic        [16:0]                dim_sum;

    // multiply stage, operand b is never negative
    always_ff @(posedge i_clk) begin
        r_prod     <= i_req.mul_a * $signed(i_req.mul_b);
        r_is_blend <= i_req.is_blend;
        r_base     <= i_req.base;
    end

    // blend: a * 2^F + (b - a) * p, floored, always within 0..255
    assign blend_acc = r_prod
        + $signed({2'b00, r_base, {rlc_pkg::FRACTION_BITS{1'b0}}});

    // divide by 255 for products up to 16 bits: (x + (x >> 8) + 1) >> 8
    assign dim_sum = {1'b0, r_prod[15:0]} + {9'd0, r_prod[15:8]} + 17'd1;

    // result select
    always_comb begin
        if (r_is_blend) begin
            o_value = blend_acc[rlc_pkg::FRACTION_BITS+7:rlc_pkg::FRACTION_BITS];
        end else begin
            o_value = dim_sum[15:8];
        end
    end

endmodule
